@@ hdl/two_link_inverse_kinematics_assert.svh @@
// ----------------------------------------------------------------------------
// Two-link inverse kinematics assertion macros
// Concurrent assertion wrappers used by the top-level RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef TWO_LINK_INVERSE_KINEMATICS_ASSERT_SVH
`define TWO_LINK_INVERSE_KINEMATICS_ASSERT_SVH

`ifndef SYNTHESIS

`define TLIK_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define TLIK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define TLIK_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define TLIK_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/tlik_pkg.sv @@
// ----------------------------------------------------------------------------
// tlik_pkg
// Types, fixed-point constants and helpers of the two-link IK pipeline.
// ----------------------------------------------------------------------------
package tlik_pkg;

  localparam int ANG_W = 32;   // angles in degrees, 16 fraction bits
  localparam int MAG_W = 32;   // magnitudes of law-of-cosines terms
  localparam int QB    = 31;   // arccos argument magnitude, Q1.30
  localparam int CW    = 33;   // CORDIC vector width
  localparam int RAD_W = 62;   // radicand of sqrt(1 - t^2)

  localparam logic signed [ANG_W-1:0] DEG90  = 32'sd5898240;
  localparam logic signed [ANG_W-1:0] DEG180 = 32'sd11796480;
  localparam logic signed [ANG_W-1:0] DEG360 = 32'sd23592960;
  localparam logic [QB-1:0]           Q30_ONE = QB'(1) << 30;
  localparam logic [RAD_W-1:0]        Q60_ONE = RAD_W'(1) << 60;

  // atan(2^-i) in degrees with 16 fraction bits.
  localparam int ATAN_TAB [32] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef enum logic [1:0] {
    CFG_LOWER_LEN = 2'd0,
    CFG_UPPER_LEN = 2'd1,
    CFG_ANG_MIN   = 2'd2,
    CFG_ANG_MAX   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] lower_angle;
    logic signed [15:0] upper_angle;
    logic               unreachable;
    logic               lower_clamped;
  } out_beat_t;

  // Per-lane control that travels with each arccos lane.
  typedef struct packed {
    logic xneg;
    logic yneg;
    logic neg;
    logic sat;
  } lane_ctl_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic [30:0]        xx;
    logic [31:0]        z2;
    logic               yneg;
  } root_side_t;

  typedef struct packed {
    lane_ctl_t   ctl;
    logic [QB-1:0] t;
  } acos_side_t;

  // One step of a truncating remainder by 360 degrees.
  function automatic logic signed [ANG_W-1:0] mod360_step(input logic signed [ANG_W-1:0] v);
    logic signed [ANG_W-1:0] res;
    if (v >= DEG360) begin
      res = v - DEG360;
    end else if (v <= -DEG360) begin
      res = v + DEG360;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

@@ hdl/tlik_stream_if.sv @@
// ----------------------------------------------------------------------------
// tlik_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface tlik_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/tlik_isqrt.sv @@
// ----------------------------------------------------------------------------
// tlik_isqrt
// Pipelined floor square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module tlik_isqrt #(
  parameter int  IN_W   = 32,
  parameter type SIDE_T = logic
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   radicand,
  input  SIDE_T             in_side,
  output logic              out_valid,
  output logic [IN_W/2-1:0] root,
  output SIDE_T             out_side
);
  localparam int N = IN_W / 2;

  logic            valid_r [N];
  logic [IN_W-1:0] rem_r   [N];
  logic [N-1:0]    root_r  [N];
  SIDE_T           side_r  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int B = N - 1 - k;
    logic            vin;
    logic [IN_W-1:0] rem_in;
    logic [IN_W-1:0] trial;
    logic [N-1:0]    root_in;
    SIDE_T           side_in;

    if (k == 0) begin : g_head
      assign vin     = in_valid;
      assign rem_in  = radicand;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_body
      assign vin     = valid_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign trial = (IN_W'(root_in) << (B + 1)) | (IN_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_in;
        if (rem_in >= trial) begin
          rem_r[k]  <= rem_in - trial;
          root_r[k] <= root_in | (N'(1) << B);
        end else begin
          rem_r[k]  <= rem_in;
          root_r[k] <= root_in;
        end
      end
    end
  end

  assign out_valid = valid_r[N-1];
  assign root      = root_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

@@ hdl/tlik_div.sv @@
// ----------------------------------------------------------------------------
// tlik_div
// Pipelined restoring divider giving floor(dividend * 2^(QB-1) / divisor).
// ----------------------------------------------------------------------------
module tlik_div #(
  parameter int  W      = 32,
  parameter int  QB     = 31,
  parameter type SIDE_T = logic
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [W-1:0]  dividend,
  input  logic [W-1:0]  divisor,
  input  SIDE_T         in_side,
  output logic          out_valid,
  output logic [QB-1:0] quotient,
  output SIDE_T         out_side
);
  logic          valid_r [QB];
  logic [W-1:0]  rem_r   [QB];
  logic [W-1:0]  den_r   [QB];
  logic [QB-1:0] quo_r   [QB];
  SIDE_T         side_r  [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int B = QB - 1 - k;
    logic          vin;
    logic [W:0]    rem_in;
    logic [W-1:0]  den_in;
    logic [QB-1:0] quo_in;
    SIDE_T         side_in;
    logic [W:0]    diff;

    // The first step compares the dividend itself; later ones shift in a zero.
    if (k == 0) begin : g_head
      assign vin     = in_valid;
      assign rem_in  = {1'b0, dividend};
      assign den_in  = divisor;
      assign quo_in  = '0;
      assign side_in = in_side;
    end else begin : g_body
      assign vin     = valid_r[k-1];
      assign rem_in  = {rem_r[k-1], 1'b0};
      assign den_in  = den_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign diff = rem_in - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_in;
        den_r[k]  <= den_in;
        if (rem_in >= {1'b0, den_in}) begin
          rem_r[k] <= diff[W-1:0];
          quo_r[k] <= quo_in | (QB'(1) << B);
        end else begin
          rem_r[k] <= rem_in[W-1:0];
          quo_r[k] <= quo_in;
        end
      end
    end
  end

  assign out_valid = valid_r[QB-1];
  assign quotient  = quo_r[QB-1];
  assign out_side  = side_r[QB-1];

endmodule

@@ hdl/tlik_cordic.sv @@
// ----------------------------------------------------------------------------
// tlik_cordic
// Pipelined vectoring CORDIC accumulating the rotation angle in degrees.
// ----------------------------------------------------------------------------
module tlik_cordic
  import tlik_pkg::*;
#(
  parameter int  STEPS  = 16,
  parameter type SIDE_T = logic
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [CW-1:0]    cx,
  input  logic signed [CW-1:0]    cy,
  input  SIDE_T                   in_side,
  output logic                    out_valid,
  output logic signed [ANG_W-1:0] ang,
  output SIDE_T                   out_side
);
  logic                    valid_r [STEPS];
  logic signed [CW-1:0]    cx_r    [STEPS];
  logic signed [CW-1:0]    cy_r    [STEPS];
  logic signed [ANG_W-1:0] ang_r   [STEPS];
  SIDE_T                   side_r  [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [ANG_W-1:0] ATAN_I = ANG_W'(ATAN_TAB[i]);
    logic                    vin;
    logic signed [CW-1:0]    cx_in;
    logic signed [CW-1:0]    cy_in;
    logic signed [ANG_W-1:0] ang_in;
    SIDE_T                   side_in;

    if (i == 0) begin : g_head
      assign vin     = in_valid;
      assign cx_in   = cx;
      assign cy_in   = cy;
      assign ang_in  = '0;
      assign side_in = in_side;
    end else begin : g_body
      assign vin     = valid_r[i-1];
      assign cx_in   = cx_r[i-1];
      assign cy_in   = cy_r[i-1];
      assign ang_in  = ang_r[i-1];
      assign side_in = side_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (en) begin
        valid_r[i] <= vin;
      end
    end

    // Rotate toward the x axis; the sign of y picks the direction.
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i] <= side_in;
        if (cy_in > 0) begin
          cx_r[i]  <= cx_in + (cy_in >>> i);
          cy_r[i]  <= cy_in - (cx_in >>> i);
          ang_r[i] <= ang_in + ATAN_I;
        end else begin
          cx_r[i]  <= cx_in - (cy_in >>> i);
          cy_r[i]  <= cy_in + (cx_in >>> i);
          ang_r[i] <= ang_in - ATAN_I;
        end
      end
    end
  end

  assign out_valid = valid_r[STEPS-1];
  assign ang       = ang_r[STEPS-1];
  assign out_side  = side_r[STEPS-1];

endmodule

@@ hdl/two_link_inverse_kinematics.sv @@
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics
// Joint angles of a planar two-link arm for a target point, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                            | sync
//  in_s    | in  | goal_x, goal_y                                     | valid/ready
//  out_m   | out | lower_angle, upper_angle, unreachable, lower_clamped | valid/ready
//  cfg_*   | in  | link lengths, lower angle limits                   | write enable
//
// One beat enters per cycle while the output is not stalled; the path runs through
// the reach square root, the arccos dividers, the sqrt(1 - t^2) unit and
// the CORDIC chain, all of which advance together.
// A stalled output freezes the whole pipeline; in_s.ready follows the output stage.
// Synchronous reset clears all valid bits and loads the default configuration.
// ----------------------------------------------------------------------------
module two_link_inverse_kinematics
  import tlik_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  tlik_stream_if.sink   in_s,
  tlik_stream_if.source out_m,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);
  // ---------------- configuration ----------------
  logic [14:0]        lower_len_r;
  logic [14:0]        upper_len_r;
  logic signed [15:0] ang_min_r;
  logic signed [15:0] ang_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_len_r <= 15'd9216;
      upper_len_r <= 15'd7383;
      ang_min_r   <= -16'sd4800;
      ang_max_r   <= 16'sd4800;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LOWER_LEN: lower_len_r <= cfg_wdata[14:0];
        CFG_UPPER_LEN: upper_len_r <= cfg_wdata[14:0];
        CFG_ANG_MIN:   ang_min_r   <= cfg_wdata;
        CFG_ANG_MAX:   ang_max_r   <= cfg_wdata;
      endcase
    end
  end

  // Link products change only with configuration; user must keep it quiet while busy, not enforced.
  logic [29:0] ll_r, uu_r, lu_r;
  always_ff @(posedge clk) begin
    ll_r <= 30'(lower_len_r) * 30'(lower_len_r);
    uu_r <= 30'(upper_len_r) * 30'(upper_len_r);
    lu_r <= 30'(lower_len_r) * 30'(upper_len_r);
  end

  // ---------------- flow control ----------------
  logic      en;
  logic      out_valid_r;
  out_beat_t out_r;

  assign en          = !out_valid_r || out_m.ready;
  assign in_s.ready  = en;
  assign out_m.valid = out_valid_r;
  assign out_m.data  = out_r;

  // ---------------- stage 1: squares ----------------
  logic signed [15:0] x0, y0;
  logic signed [31:0] xsq, ysq;
  logic               v1_r;
  logic signed [15:0] x1_r;
  logic               yneg1_r;
  logic [30:0]        xx1_r, yy1_r;

  // A zero coordinate is nudged to 3 LSB.
  assign x0  = (in_s.data.goal_x == 16'sd0) ? 16'sd3 : in_s.data.goal_x;
  assign y0  = (in_s.data.goal_y == 16'sd0) ? 16'sd3 : in_s.data.goal_y;
  assign xsq = 32'(x0) * 32'(x0);
  assign ysq = 32'(y0) * 32'(y0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= x0;
      yneg1_r <= y0[15];
      xx1_r   <= xsq[30:0];
      yy1_r   <= ysq[30:0];
    end
  end

  // ---------------- stage 2: squared reach ----------------
  logic       v2_r;
  root_side_t rs2_r;
  logic [31:0] z2_2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z2_2_r     <= 32'(xx1_r) + 32'(yy1_r);
      rs2_r.x    <= x1_r;
      rs2_r.xx   <= xx1_r;
      rs2_r.z2   <= 32'(xx1_r) + 32'(yy1_r);
      rs2_r.yneg <= yneg1_r;
    end
  end

  logic       vz;
  logic [15:0] z;
  root_side_t rsz;

  tlik_isqrt #(.IN_W(32), .SIDE_T(root_side_t)) u_reach (
    .clk, .rst_n, .en,
    .in_valid(v2_r), .radicand(z2_2_r), .in_side(rs2_r),
    .out_valid(vz), .root(z), .out_side(rsz)
  );

  // ---------------- stage 3: law-of-cosines terms ----------------
  logic signed [32:0] z_ext, x_ext;
  logic               v3_r;
  logic signed [32:0] zx3_r;
  logic [31:0]        zl3_r;
  logic [31:0]        ny3_r;
  logic signed [33:0] na3_r, nb3_r;
  logic               xneg3_r, yneg3_r;

  assign z_ext = $signed({17'b0, z});
  assign x_ext = 33'(rsz.x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= vz;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zx3_r   <= z_ext * x_ext;
      zl3_r   <= 32'(z) * 32'(lower_len_r);
      ny3_r   <= {rsz.xx, 1'b0};
      na3_r   <= 34'(ll_r) + 34'(rsz.z2) - 34'(uu_r);
      nb3_r   <= 34'(uu_r) + 34'(ll_r) - 34'(rsz.z2);
      xneg3_r <= rsz.x[15];
      yneg3_r <= rsz.yneg;
    end
  end

  // ---------------- stage 4: magnitudes ----------------
  logic [32:0]      zx_abs;
  logic [33:0]      na_abs, nb_abs;
  logic             v4_r;
  logic [MAG_W-1:0] an4_r  [3];
  logic [MAG_W-1:0] ad4_r  [3];
  lane_ctl_t        ctl4_r [3];

  assign zx_abs = zx3_r[32] ? 33'(-zx3_r) : 33'(zx3_r);
  assign na_abs = na3_r[33] ? 34'(-na3_r) : 34'(na3_r);
  assign nb_abs = nb3_r[33] ? 34'(-nb3_r) : 34'(nb3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  // Lane 0 is the angle to the target, lane 1 the lower joint, lane 2 the elbow.
  always_ff @(posedge clk) begin
    if (en) begin
      an4_r[0]  <= ny3_r;
      ad4_r[0]  <= {zx_abs[30:0], 1'b0};
      ctl4_r[0] <= '{xneg: xneg3_r, yneg: yneg3_r, neg: xneg3_r, sat: 1'b0};
      an4_r[1]  <= na_abs[MAG_W-1:0];
      ad4_r[1]  <= {zl3_r[30:0], 1'b0};
      ctl4_r[1] <= '{xneg: xneg3_r, yneg: yneg3_r, neg: na3_r[33], sat: 1'b0};
      an4_r[2]  <= nb_abs[MAG_W-1:0];
      ad4_r[2]  <= {1'b0, lu_r, 1'b0};
      ctl4_r[2] <= '{xneg: xneg3_r, yneg: yneg3_r, neg: nb3_r[33], sat: 1'b0};
    end
  end

  // ---------------- arccos lanes ----------------
  logic                    vdiv [3];
  logic                    vsq  [3];
  logic                    vcor [3];
  logic signed [ANG_W-1:0] ang_w [3];
  lane_ctl_t               ctl_w [3];
  logic                    v6_r, v7_r, v8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v6_r <= vdiv[0] & vdiv[1] & vdiv[2];
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    lane_ctl_t        ctl_in;
    logic [QB-1:0]    quo;
    lane_ctl_t        ctl_q;
    lane_ctl_t        ctl_t;
    logic [QB-1:0]    t_sel;
    logic [QB-1:0]    t6_r, t7_r, t8_r;
    lane_ctl_t        ctl6_r, ctl7_r, ctl8_r;
    logic [RAD_W-1:0] tt7_r, rad8_r;
    logic [QB-1:0]    cy_root;
    acos_side_t       as8, as_out;

    // A zero divisor or a numerator above it saturates the argument to one.
    always_comb begin
      ctl_in     = ctl4_r[g];
      ctl_in.sat = (ad4_r[g] == '0) || (an4_r[g] > ad4_r[g]);
    end

    tlik_div #(.W(MAG_W), .QB(QB), .SIDE_T(lane_ctl_t)) u_div (
      .clk, .rst_n, .en,
      .in_valid(v4_r), .dividend(an4_r[g]), .divisor(ad4_r[g]), .in_side(ctl_in),
      .out_valid(vdiv[g]), .quotient(quo), .out_side(ctl_q)
    );

    assign t_sel = ctl_q.sat ? Q30_ONE : quo;

    // A zero argument counts as positive.
    always_comb begin
      ctl_t     = ctl_q;
      ctl_t.neg = ctl_q.neg && (t_sel != '0);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        t6_r       <= t_sel;
        ctl6_r     <= ctl_t;
        t7_r       <= t6_r;
        ctl7_r     <= ctl6_r;
        tt7_r      <= RAD_W'(t6_r) * RAD_W'(t6_r);
        t8_r       <= t7_r;
        ctl8_r     <= ctl7_r;
        rad8_r     <= Q60_ONE - tt7_r;
      end
    end

    assign as8 = '{ctl: ctl8_r, t: t8_r};

    tlik_isqrt #(.IN_W(RAD_W), .SIDE_T(acos_side_t)) u_sine (
      .clk, .rst_n, .en,
      .in_valid(v8_r), .radicand(rad8_r), .in_side(as8),
      .out_valid(vsq[g]), .root(cy_root), .out_side(as_out)
    );

    tlik_cordic #(.STEPS(CORDIC_STEPS), .SIDE_T(lane_ctl_t)) u_cordic (
      .clk, .rst_n, .en,
      .in_valid(vsq[g]),
      .cx($signed(CW'(as_out.t))), .cy($signed(CW'(cy_root))),
      .in_side(as_out.ctl),
      .out_valid(vcor[g]), .ang(ang_w[g]), .out_side(ctl_w[g])
    );
  end

  // ---------------- stage 9: signed law-of-cosines angles ----------------
  logic                    v9_r;
  logic signed [ANG_W-1:0] a9_r [3];
  logic                    flag9_r, both9_r;
  logic signed [ANG_W-1:0] acos_w [3];
  logic                    sneg_w [3];

  assign sneg_w[0] = ctl_w[0].yneg;
  assign sneg_w[1] = ctl_w[1].xneg;
  assign sneg_w[2] = ctl_w[2].xneg;

  for (genvar g = 0; g < 3; g++) begin : g_sign
    // A negative argument folds through acos(t) = 180 - acos(-t).
    assign acos_w[g] = ctl_w[g].neg ? (DEG180 - ang_w[g]) : ang_w[g];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else if (en) begin
      v9_r <= vcor[0] & vcor[1] & vcor[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < 3; g++) begin
        a9_r[g] <= sneg_w[g] ? -acos_w[g] : acos_w[g];
      end
      flag9_r <= ctl_w[0].sat | ctl_w[1].sat | ctl_w[2].sat;
      both9_r <= ctl_w[0].xneg & ctl_w[0].yneg;
    end
  end

  // ---------------- stages 10 to 13: joint angles and wrap ----------------
  logic                    v10_r, v11_r, v12_r, v13_r, v14_r;
  logic signed [ANG_W-1:0] low10_r, b10_r;
  logic signed [ANG_W-1:0] up11_r, lo11_r, up12_r, lo12_r, up13_r, lo13_r;
  logic                    flag10_r, flag11_r, flag12_r, flag13_r, flag14_r;
  logic                    both10_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0;
      v11_r <= 1'b0;
      v12_r <= 1'b0;
      v13_r <= 1'b0;
      v14_r <= 1'b0;
    end else if (en) begin
      v10_r <= v9_r;
      v11_r <= v10_r;
      v12_r <= v11_r;
      v13_r <= v12_r;
      v14_r <= v13_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      low10_r  <= DEG90 - a9_r[1] - a9_r[0];
      b10_r    <= a9_r[2];
      flag10_r <= flag9_r;
      both10_r <= both9_r;

      up11_r   <= low10_r + DEG180 - b10_r;
      lo11_r   <= both10_r ? (low10_r - DEG360) : low10_r;
      flag11_r <= flag10_r;

      up12_r   <= mod360_step(up11_r);
      lo12_r   <= mod360_step(lo11_r);
      flag12_r <= flag11_r;

      up13_r   <= mod360_step(up12_r);
      lo13_r   <= mod360_step(lo12_r);
      flag13_r <= flag12_r;
    end
  end

  // ---------------- stage 14: round to 1/64 degree ----------------
  logic signed [ANG_W-1:0] up_rnd, lo_rnd;
  logic signed [15:0]      up14_r, lo14_r;

  assign up_rnd = (up13_r + 32'sd512) >>> 10;
  assign lo_rnd = (lo13_r + 32'sd512) >>> 10;

  always_ff @(posedge clk) begin
    if (en) begin
      up14_r   <= up_rnd[15:0];
      lo14_r   <= lo_rnd[15:0];
      flag14_r <= flag13_r;
    end
  end

  // ---------------- stage 15: clamp and output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v14_r;
    end
  end

  // The upper limit is tested first, so a value above it resolves to it even when the limits are crossed.
  always_ff @(posedge clk) begin
    if (en) begin
      out_r.upper_angle <= up14_r;
      out_r.unreachable <= flag14_r;
      if (lo14_r > ang_max_r) begin
        out_r.lower_angle   <= ang_max_r;
        out_r.lower_clamped <= 1'b1;
      end else if (lo14_r < ang_min_r) begin
        out_r.lower_angle   <= ang_min_r;
        out_r.lower_clamped <= 1'b1;
      end else begin
        out_r.lower_angle   <= lo14_r;
        out_r.lower_clamped <= 1'b0;
      end
    end
  end

  // ---------------- checks ----------------
`include "two_link_inverse_kinematics_assert.svh"

  `TLIK_ASSERT_SAME(a_stall_blocks_input, clk, rst_n, out_m.valid && !out_m.ready, !in_s.ready)
  `TLIK_ASSERT_NEXT(a_accept_enters_pipe, clk, rst_n, in_s.valid && in_s.ready, v1_r)
  `TLIK_ASSERT_SAME(a_clamp_hits_limit, clk, rst_n, out_m.valid && out_m.data.lower_clamped,
                    out_m.data.lower_angle == ang_min_r || out_m.data.lower_angle == ang_max_r)
  `TLIK_ASSERT_SAME(a_lower_in_limits, clk, rst_n, out_m.valid && (ang_min_r <= ang_max_r),
                    out_m.data.lower_angle >= ang_min_r && out_m.data.lower_angle <= ang_max_r)

endmodule
